// File: hw/rtl/tlptm_pkg.sv
// shared constants, codes and controller/datapath interface types of the page table manager
package tlptm_pkg;

  localparam int unsigned TABLE_PAGES       = 16;
  localparam int unsigned ENTRIES_PER_TABLE = 512;
  localparam int unsigned MAX_RUN           = 64;
  localparam int unsigned VA_PAGE_LIMIT     = 67108864;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned VPN_W    = 27;
  localparam int unsigned PPN_W    = 44;
  localparam int unsigned PERMS_W  = 8;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned ENTRY_W  = 54;

  localparam int unsigned IDX_W       = $clog2(ENTRIES_PER_TABLE);
  localparam int unsigned PAGE_W      = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int unsigned NFREE_W     = $clog2(TABLE_PAGES + 1);
  localparam int unsigned ADDR_W      = PAGE_W + IDX_W;
  localparam int unsigned STORE_DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE;
  localparam int unsigned RUN_W       = $clog2(MAX_RUN + 1);
  localparam int unsigned RANGE_W     = VPN_W + 1;
  localparam int unsigned LEVEL_W     = 2;
  localparam int unsigned PPN_LSB     = 10;

  localparam logic [LEVEL_W-1:0] TOP_LEVEL = 2'd2;
  localparam logic [PERMS_W-1:0] FLAG_V    = 8'h01;

  typedef enum logic [ACTION_W-1:0] {
    ACT_MAP    = 2'd0,
    ACT_UNMAP  = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_BAD    = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_REMAP    = 3'd1,
    ST_NOSPACE  = 3'd2,
    ST_RANGE    = 3'd3,
    ST_UNMAPPED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ENT_ZERO = 2'd0,
    ENT_READ = 2'd1,
    ENT_LEAF = 2'd2
  } ent_sel_e;

  // commands from the controller
  typedef struct packed {
    logic     load;
    logic     walk_start;
    logic     mem_rd;
    logic     descend;
    logic     alloc;
    logic     clr_wr;
    logic     leaf_wr;
    logic     leaf_clr;
    logic     next_page;
    logic     res_load;
    status_e  res_status;
    ent_sel_e res_ent;
    logic     res_freed;
    logic     res_last;
  } ctrl_cmd_t;

  // status back to the controller
  typedef struct packed {
    action_e action;
    logic    range_bad;
    logic    level_zero;
    logic    ent_valid;
    logic    ptr_bad;
    logic    space_full;
    logic    clr_done;
    logic    is_last;
    logic    release_pages;
    logic    res_last;
  } dp_stat_t;

endpackage

// File: hw/rtl/three_level_page_table_manager.sv
// three-level page table manager: top level joining controller and datapath
//
// A request is one input transfer (in_valid_i high, in_stall_o low) naming an action:
// map a run of pages, unmap a run of pages, or look up one page. Each page handled
// gives one output transfer (out_valid_o high, out_stall_i low); last_o marks the
// final one of a request. The block works on one request at a time and holds
// in_stall_o high from acceptance until the final result has been transferred.
// Each page walks three table levels through the single-port table store; at each
// level the read state presents the address and the evaluate state works on the
// registered read data, then the output state shows the result, and a decode
// state comes ahead of the first page. Every table page allocated during a map is
// swept to zero one entry per cycle before the walk goes on to the new page.
// Range and unused-action errors are set in the decode state and shown in the
// output state; the input is free again in the cycle after a request's final transfer.
// While out_stall_i is high the result stays on the outputs and the walk waits.
// After reset the root table page is swept to zero with in_stall_o high; all
// other table pages are cleared when they are allocated.
module three_level_page_table_manager (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tlptm_pkg::ACTION_W-1:0] action_i,
  input  logic [tlptm_pkg::VPN_W-1:0]    vpn_i,
  input  logic [tlptm_pkg::PPN_W-1:0]    ppn_i,
  input  logic [tlptm_pkg::PERMS_W-1:0]  perms_i,
  input  logic [tlptm_pkg::COUNT_W-1:0]  page_count_i,
  input  logic                           release_pages_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tlptm_pkg::STATUS_W-1:0] status_o,
  output logic [tlptm_pkg::ENTRY_W-1:0]  entry_o,
  output logic [tlptm_pkg::PPN_W-1:0]    freed_ppn_o,
  output logic                           freed_valid_o,
  output logic                           last_o
);
  import tlptm_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  tlptm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  tlptm_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .action_i        (action_i),
    .vpn_i           (vpn_i),
    .ppn_i           (ppn_i),
    .perms_i         (perms_i),
    .page_count_i    (page_count_i),
    .release_pages_i (release_pages_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .status_o        (status_o),
    .entry_o         (entry_o),
    .freed_ppn_o     (freed_ppn_o),
    .freed_valid_o   (freed_valid_o),
    .last_o          (last_o)
  );

  // no new request while a result is pending
  a_no_accept_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request accepted while a result is pending");

  // a freed page only comes with a successful unmap
  a_freed_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && freed_valid_o) |-> (status_o == ST_OK))
    else $error("freed page reported with error status");

  // remap, table space and range errors end the run
  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_REMAP || status_o == ST_NOSPACE ||
     status_o == ST_RANGE)) |-> last_o)
    else $error("run continued after a terminating error");

  // an accepted request blocks the input in the next cycle
  a_accept_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after a transfer");

endmodule

// File: hw/rtl/tlptm_datapath.sv
// datapath of the page table manager: request registers, table store, walk and result registers
module tlptm_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [tlptm_pkg::ACTION_W-1:0] action_i,
  input  logic [tlptm_pkg::VPN_W-1:0]    vpn_i,
  input  logic [tlptm_pkg::PPN_W-1:0]    ppn_i,
  input  logic [tlptm_pkg::PERMS_W-1:0]  perms_i,
  input  logic [tlptm_pkg::COUNT_W-1:0]  page_count_i,
  input  logic                           release_pages_i,
  input  tlptm_pkg::ctrl_cmd_t           cmd_i,
  output tlptm_pkg::dp_stat_t            stat_o,
  output logic [tlptm_pkg::STATUS_W-1:0] status_o,
  output logic [tlptm_pkg::ENTRY_W-1:0]  entry_o,
  output logic [tlptm_pkg::PPN_W-1:0]    freed_ppn_o,
  output logic                           freed_valid_o,
  output logic                           last_o
);
  import tlptm_pkg::*;

  logic [ENTRY_W-1:0] mem [STORE_DEPTH];

  action_e            action_q;
  logic [VPN_W-1:0]   vpn_q;
  logic [PPN_W-1:0]   ppn_q;
  logic [PERMS_W-1:0] perms_q;
  logic               rel_q;
  logic [RUN_W-1:0]   remain_q;
  logic [LEVEL_W-1:0] level_q;
  logic [ENTRY_W-1:0] rdata_q;

  logic [PAGE_W-1:0]  page_q,      page_d;
  logic [NFREE_W-1:0] next_free_q, next_free_d;
  logic [IDX_W-1:0]   clr_cnt_q,   clr_cnt_d;

  status_e            status_q;
  logic [ENTRY_W-1:0] entry_q;
  logic [PPN_W-1:0]   freed_ppn_q;
  logic               freed_valid_q;
  logic               last_q;

  logic [COUNT_W-1:0] norm_cnt;
  logic [IDX_W-1:0]   idx;
  logic [ADDR_W-1:0]  walk_addr;
  logic [ADDR_W-1:0]  waddr;
  logic [ENTRY_W-1:0] wdata;
  logic               we;
  logic [PPN_W-1:0]   nxt;
  logic [ENTRY_W-1:0] new_leaf;
  logic [RANGE_W-1:0] range_end;

  always_comb begin
    norm_cnt = page_count_i;
    if (page_count_i == '0) begin
      norm_cnt = COUNT_W'(1);
    end else if (page_count_i > COUNT_W'(MAX_RUN)) begin
      norm_cnt = COUNT_W'(MAX_RUN);
    end
  end

  always_comb begin
    case (level_q)
      2'd2:    idx = vpn_q[3*IDX_W-1:2*IDX_W];
      2'd1:    idx = vpn_q[2*IDX_W-1:IDX_W];
      default: idx = vpn_q[IDX_W-1:0];
    endcase
  end

  assign walk_addr = {page_q, idx};
  assign nxt       = rdata_q[ENTRY_W-1:PPN_LSB];
  assign new_leaf  = {ppn_q, 2'b00, perms_q | FLAG_V};
  assign range_end = {1'b0, vpn_q} + RANGE_W'(remain_q);

  // one write port shared by pointer, clear and leaf writes
  assign we    = cmd_i.alloc | cmd_i.clr_wr | cmd_i.leaf_wr | cmd_i.leaf_clr;
  assign waddr = cmd_i.clr_wr ? {page_q, clr_cnt_q} : walk_addr;

  always_comb begin
    wdata = '0;
    if (cmd_i.alloc) begin
      wdata = {PPN_W'(next_free_q), 2'b00, FLAG_V};
    end else if (cmd_i.leaf_wr) begin
      wdata = new_leaf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem[walk_addr];
    end
  end

  always_comb begin
    page_d      = page_q;
    next_free_d = next_free_q;
    clr_cnt_d   = clr_cnt_q;
    if (cmd_i.walk_start) begin
      page_d = '0;
    end else if (cmd_i.descend) begin
      page_d = nxt[PAGE_W-1:0];
    end else if (cmd_i.alloc) begin
      page_d      = next_free_q[PAGE_W-1:0];
      next_free_d = next_free_q + NFREE_W'(1);
      clr_cnt_d   = '0;
    end
    if (cmd_i.clr_wr) begin
      clr_cnt_d = clr_cnt_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q      <= '0;
      next_free_q <= NFREE_W'(1);
      clr_cnt_q   <= '0;
    end else begin
      page_q      <= page_d;
      next_free_q <= next_free_d;
      clr_cnt_q   <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_e'(action_i);
      vpn_q    <= vpn_i;
      ppn_q    <= ppn_i;
      perms_q  <= perms_i;
      rel_q    <= release_pages_i;
      // lookup and unused actions handle a single page
      if (action_e'(action_i) == ACT_MAP || action_e'(action_i) == ACT_UNMAP) begin
        remain_q <= norm_cnt[RUN_W-1:0];
      end else begin
        remain_q <= RUN_W'(1);
      end
    end else if (cmd_i.next_page) begin
      vpn_q    <= vpn_q + VPN_W'(1);
      ppn_q    <= ppn_q + PPN_W'(1);
      remain_q <= remain_q - RUN_W'(1);
    end

    if (cmd_i.walk_start) begin
      level_q <= TOP_LEVEL;
    end else if (cmd_i.descend || cmd_i.alloc) begin
      level_q <= level_q - LEVEL_W'(1);
    end

    if (cmd_i.res_load) begin
      status_q <= cmd_i.res_status;
      case (cmd_i.res_ent)
        ENT_READ: entry_q <= rdata_q;
        ENT_LEAF: entry_q <= new_leaf;
        default:  entry_q <= '0;
      endcase
      freed_ppn_q   <= cmd_i.res_freed ? nxt : '0;
      freed_valid_q <= cmd_i.res_freed;
      last_q        <= cmd_i.res_last;
    end
  end

  always_comb begin
    stat_o.action        = action_q;
    stat_o.range_bad     = range_end > RANGE_W'(VA_PAGE_LIMIT);
    stat_o.level_zero    = level_q == '0;
    stat_o.ent_valid     = rdata_q[0];
    stat_o.ptr_bad       = nxt >= PPN_W'(TABLE_PAGES);
    stat_o.space_full    = next_free_q >= NFREE_W'(TABLE_PAGES);
    stat_o.clr_done      = clr_cnt_q == '1;
    stat_o.is_last       = remain_q == RUN_W'(1);
    stat_o.release_pages = rel_q;
    stat_o.res_last      = last_q;
  end

  assign status_o      = status_q;
  assign entry_o       = entry_q;
  assign freed_ppn_o   = freed_ppn_q;
  assign freed_valid_o = freed_valid_q;
  assign last_o        = last_q;

endmodule

// File: hw/rtl/tlptm_ctrl.sv
// controller state machine of the page table manager
module tlptm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output tlptm_pkg::ctrl_cmd_t  cmd_o,
  input  tlptm_pkg::dp_stat_t   stat_i
);
  import tlptm_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_RD,
    S_EVAL,
    S_ALLOC_CLR,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   is_map;
  logic   fail_last;

  assign is_map    = stat_i.action == ACT_MAP;
  // a map run stops at its first error, other runs go on
  assign fail_last = is_map | stat_i.is_last;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        // root page sweep after reset
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.action == ACT_BAD || (is_map && stat_i.range_bad)) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_RANGE;
          cmd_o.res_ent    = ENT_ZERO;
          cmd_o.res_last   = 1'b1;
          state_d          = S_OUT;
        end else begin
          cmd_o.walk_start = 1'b1;
          state_d          = S_RD;
        end
      end
      S_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.res_ent = ENT_ZERO;
        if (!stat_i.level_zero) begin
          if (stat_i.ent_valid && !stat_i.ptr_bad) begin
            cmd_o.descend = 1'b1;
            state_d       = S_RD;
          end else if (!stat_i.ent_valid && is_map && !stat_i.space_full) begin
            cmd_o.alloc = 1'b1;
            state_d     = S_ALLOC_CLR;
          end else begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = is_map ? ST_NOSPACE : ST_UNMAPPED;
            cmd_o.res_last   = fail_last;
            state_d          = S_OUT;
          end
        end else begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_last = stat_i.is_last;
          state_d        = S_OUT;
          case (stat_i.action)
            ACT_MAP: begin
              if (stat_i.ent_valid) begin
                cmd_o.res_status = ST_REMAP;
                cmd_o.res_ent    = ENT_READ;
                cmd_o.res_last   = 1'b1;
              end else begin
                cmd_o.leaf_wr    = 1'b1;
                cmd_o.res_status = ST_OK;
                cmd_o.res_ent    = ENT_LEAF;
              end
            end
            ACT_UNMAP: begin
              if (stat_i.ent_valid) begin
                cmd_o.leaf_clr   = 1'b1;
                cmd_o.res_status = ST_OK;
                cmd_o.res_ent    = ENT_READ;
                cmd_o.res_freed  = stat_i.release_pages;
              end else begin
                cmd_o.res_status = ST_UNMAPPED;
              end
            end
            default: begin
              cmd_o.res_last = 1'b1;
              if (stat_i.ent_valid) begin
                cmd_o.res_status = ST_OK;
                cmd_o.res_ent    = ENT_READ;
              end else begin
                cmd_o.res_status = ST_UNMAPPED;
              end
            end
          endcase
        end
      end
      S_ALLOC_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_done) begin
          state_d = S_RD;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          if (stat_i.res_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.next_page  = 1'b1;
            cmd_o.walk_start = 1'b1;
            state_d          = S_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = state_q == S_OUT;

endmodule
